// File: design/owm_pkg.sv
// Shared types and constants for the single-wire bus master.
// Used by owm_cfg and one_wire_bus_master; depends on nothing.
`default_nettype none

package owm_pkg;

    // Command codes on the op field
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_RECOVER = 3'd2,
        REG_SLOT_START    = 3'd3,
        REG_READ_SAMPLE   = 3'd4,
        REG_SLOT_HOLD     = 3'd5,
        REG_WRITE_RECOVER = 3'd6
    } reg_idx_t;

    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned TICK_W     = 10;

    // Reset values of the timing registers
    localparam logic [9:0] RESET_LOW_INIT     = 10'd490;
    localparam logic [7:0] PRESENCE_WAIT_INIT = 8'd68;
    localparam logic [9:0] RESET_RECOVER_INIT = 10'd422;
    localparam logic [3:0] SLOT_START_INIT    = 4'd2;
    localparam logic [3:0] READ_SAMPLE_INIT   = 4'd4;
    localparam logic [6:0] SLOT_HOLD_INIT     = 7'd62;
    localparam logic [3:0] WRITE_RECOVER_INIT = 4'd2;

    // Timing register set handed from the register file to the sequencer
    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_wait_ticks;
        logic [9:0] reset_recovery_ticks;
        logic [3:0] slot_start_ticks;
        logic [3:0] read_sample_ticks;
        logic [6:0] slot_hold_ticks;
        logic [3:0] write_recovery_ticks;
    } timing_t;

endpackage

`default_nettype wire

// File: design/owm_cfg.sv
// Timing register file of the single-wire bus master.
// Depends on owm_pkg for the register indexes and the timing_t struct.
`default_nettype none

module owm_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [2:0]                   wr_index,
    input  wire logic [owm_pkg::CFG_DATA_W-1:0] wr_data,
    output owm_pkg::timing_t                  timing
);

    owm_pkg::timing_t timing_reg;

    // Write one register per transfer; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_ticks      <= owm_pkg::RESET_LOW_INIT;
            timing_reg.presence_wait_ticks  <= owm_pkg::PRESENCE_WAIT_INIT;
            timing_reg.reset_recovery_ticks <= owm_pkg::RESET_RECOVER_INIT;
            timing_reg.slot_start_ticks     <= owm_pkg::SLOT_START_INIT;
            timing_reg.read_sample_ticks    <= owm_pkg::READ_SAMPLE_INIT;
            timing_reg.slot_hold_ticks      <= owm_pkg::SLOT_HOLD_INIT;
            timing_reg.write_recovery_ticks <= owm_pkg::WRITE_RECOVER_INIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                owm_pkg::REG_RESET_LOW:
                    timing_reg.reset_low_ticks <= wr_data[9:0];
                owm_pkg::REG_PRESENCE_WAIT:
                    timing_reg.presence_wait_ticks <= wr_data[7:0];
                owm_pkg::REG_RESET_RECOVER:
                    timing_reg.reset_recovery_ticks <= wr_data[9:0];
                owm_pkg::REG_SLOT_START:
                    timing_reg.slot_start_ticks <= wr_data[3:0];
                owm_pkg::REG_READ_SAMPLE:
                    timing_reg.read_sample_ticks <= wr_data[3:0];
                owm_pkg::REG_SLOT_HOLD:
                    timing_reg.slot_hold_ticks <= wr_data[6:0];
                owm_pkg::REG_WRITE_RECOVER:
                    timing_reg.write_recovery_ticks <= wr_data[3:0];
                default:
                    ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

`default_nettype wire

// File: design/one_wire_bus_master.sv
// Top level of the single-wire bus master: tick sequencer and result register.
// Depends on owm_pkg and owm_cfg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------
//   in      | in        | in_valid / in_ready   | op, data_byte, line_in
//   out     | out       | out_valid / out_ready | drive_low, busy_res, done_res,
//           |           |                       | read_value, no_presence
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick item per cycle unless the output stalls: each accepted tick updates the sequencer
// state and loads the result register in the same cycle, so one result appears per tick.
// in_ready stays high while the result register is empty or being drained;
// a stalled output holds the result and blocks further ticks until taken.
// Reset returns the sequencer to idle and the timing registers to defaults.
// cfg_ready is always high; a register write goes straight into the timing register file.
`default_nettype none

module one_wire_bus_master (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     op,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           line_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                drive_low,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [7:0]                          read_value,
    output logic                                no_presence,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [owm_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RST_LOW     = 4'd1,
        PH_RST_WAIT    = 4'd2,
        PH_RST_RECOVER = 4'd3,
        PH_SLOT_START  = 4'd4,
        PH_W_HOLD      = 4'd5,
        PH_W_RECOVER   = 4'd6,
        PH_R_RELEASE   = 4'd7,
        PH_R_HOLD      = 4'd8
    } phase_t;

    owm_pkg::timing_t timing;

    phase_t                      phase_reg,    phase_next;
    logic [owm_pkg::TICK_W-1:0]  tick_reg,     tick_next;
    logic [7:0]                  shift_reg,    shift_next;
    logic [2:0]                  bit_reg,      bit_next;
    logic [1:0]                  kind_reg,     kind_next;
    logic                        presence_reg, presence_next;
    logic [7:0]                  last_read_reg, last_read_next;

    logic                        out_valid_reg;
    logic                        drive_reg, busy_reg, done_reg;
    logic                        drive_next, busy_next, done_next;

    logic                        in_xfer;
    phase_t                      cur_phase;
    logic [owm_pkg::TICK_W-1:0]  cur_tick;
    logic [7:0]                  cur_shift;
    logic [2:0]                  cur_bit;
    logic [1:0]                  cur_kind;
    logic [owm_pkg::TICK_W-1:0]  len_raw, len_eff, tick_inc;

    owm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    // Start a command when idle: the start tick is the first tick of its first phase
    always_comb
    begin
        cur_phase = phase_reg;
        cur_tick  = tick_reg;
        cur_shift = shift_reg;
        cur_bit   = bit_reg;
        cur_kind  = kind_reg;
        if (phase_reg == PH_IDLE && op != owm_pkg::OP_TICK)
        begin
            cur_kind = op;
            cur_tick = '0;
            cur_bit  = '0;
            if (op == owm_pkg::OP_RESET)
            begin
                cur_phase = PH_RST_LOW;
            end
            else
            begin
                cur_shift = (op == owm_pkg::OP_WRITE) ? data_byte : 8'd0;
                cur_phase = PH_SLOT_START;
            end
        end
    end

    // Look up the length of the current phase; zero counts as one tick
    always_comb
    begin
        case (cur_phase)
            PH_RST_LOW:     len_raw = timing.reset_low_ticks;
            PH_RST_WAIT:    len_raw = 10'(timing.presence_wait_ticks);
            PH_RST_RECOVER: len_raw = timing.reset_recovery_ticks;
            PH_SLOT_START:  len_raw = 10'(timing.slot_start_ticks);
            PH_W_HOLD:      len_raw = 10'(timing.slot_hold_ticks);
            PH_W_RECOVER:   len_raw = 10'(timing.write_recovery_ticks);
            PH_R_RELEASE:   len_raw = 10'(timing.read_sample_ticks);
            PH_R_HOLD:      len_raw = 10'(timing.slot_hold_ticks);
            default:        len_raw = 10'd1;
        endcase
        len_eff  = (len_raw == '0) ? 10'd1 : len_raw;
        tick_inc = cur_tick + 10'd1;
    end

    // Advance the sequencer by one tick
    always_comb
    begin
        phase_next     = cur_phase;
        tick_next      = cur_tick;
        shift_next     = cur_shift;
        bit_next       = cur_bit;
        kind_next      = cur_kind;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        drive_next     = 1'b0;
        busy_next      = 1'b0;
        done_next      = 1'b0;

        if (cur_phase != PH_IDLE)
        begin
            busy_next = 1'b1;
            case (cur_phase)
                PH_RST_LOW, PH_SLOT_START: drive_next = 1'b1;
                PH_W_HOLD:                 drive_next = !cur_shift[0];
                default:                   drive_next = 1'b0;
            endcase

            tick_next = tick_inc;
            if (tick_inc >= len_eff)
            begin
                tick_next = '0;
                unique case (cur_phase)
                    PH_RST_LOW:
                        phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = line_in;
                        phase_next    = PH_RST_RECOVER;
                    end
                    PH_RST_RECOVER:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_SLOT_START:
                        phase_next = (cur_kind == owm_pkg::OP_READ) ? PH_R_RELEASE : PH_W_HOLD;
                    PH_W_HOLD:
                    begin
                        shift_next = {1'b0, cur_shift[7:1]};
                        phase_next = PH_W_RECOVER;
                    end
                    PH_W_RECOVER:
                    begin
                        if (cur_bit == 3'd7)
                        begin
                            bit_next   = '0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            bit_next   = cur_bit + 3'd1;
                            phase_next = PH_SLOT_START;
                        end
                    end
                    PH_R_RELEASE:
                    begin
                        shift_next = {line_in, cur_shift[7:1]};
                        phase_next = PH_R_HOLD;
                    end
                    PH_R_HOLD:
                    begin
                        if (cur_bit == 3'd7)
                        begin
                            bit_next       = '0;
                            phase_next     = PH_IDLE;
                            last_read_next = cur_shift;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            bit_next   = cur_bit + 3'd1;
                            phase_next = PH_SLOT_START;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Hold sequencer state and the result register; update on each tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            kind_reg      <= '0;
            presence_reg  <= 1'b1;
            last_read_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                shift_reg     <= shift_next;
                bit_reg       <= bit_next;
                kind_reg      <= kind_next;
                presence_reg  <= presence_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load result payload alongside the state update
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            drive_reg <= drive_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_low   = drive_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign read_value  = last_read_reg;
    assign no_presence = presence_reg;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for one_wire_bus_master: ticks go in through a queue-fed driver, and a
// monitor checks each result against a tick-accurate model of the bus sequencer.
// Depends on owm_pkg and the one_wire_bus_master RTL only.
`timescale 1ns / 1ps

module tb_top;

    // Line level selection for generated ticks
    localparam int LVL_LOW  = 0;
    localparam int LVL_HIGH = 1;
    localparam int LVL_RAND = 2;

    localparam int CFG_W = owm_pkg::CFG_DATA_W;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_RST_LOW,
        SQ_RST_WAIT,
        SQ_RST_RECOVER,
        SQ_SLOT_START,
        SQ_W_HOLD,
        SQ_W_RECOVER,
        SQ_R_RELEASE,
        SQ_R_HOLD
    } seq_phase_t;

    typedef struct {
        owm_pkg::op_t op;
        logic [7:0]   data;
        logic         lvl;
    } tick_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic [7:0] read_value;
        logic       no_presence;
    } bus_state_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    owm_pkg::op_t          op          = owm_pkg::OP_TICK;
    logic [7:0]            data_byte   = 8'h00;
    logic                  line_in     = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic [7:0]            read_value;
    logic                  no_presence;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    owm_pkg::reg_idx_t     cfg_index   = owm_pkg::REG_RESET_LOW;
    logic [CFG_W-1:0]      cfg_data    = '0;

    // Timing registers as the block should hold them
    logic [9:0] m_reset_low     = owm_pkg::RESET_LOW_INIT;
    logic [7:0] m_presence_wait = owm_pkg::PRESENCE_WAIT_INIT;
    logic [9:0] m_reset_recover = owm_pkg::RESET_RECOVER_INIT;
    logic [3:0] m_slot_start    = owm_pkg::SLOT_START_INIT;
    logic [3:0] m_read_sample   = owm_pkg::READ_SAMPLE_INIT;
    logic [6:0] m_slot_hold     = owm_pkg::SLOT_HOLD_INIT;
    logic [3:0] m_write_recover = owm_pkg::WRITE_RECOVER_INIT;

    // Sequencer state as the block should hold it
    seq_phase_t   m_phase     = SQ_IDLE;
    logic [9:0]   m_count     = '0;
    logic [7:0]   m_shift     = '0;
    logic [2:0]   m_bit       = '0;
    owm_pkg::op_t m_kind      = owm_pkg::OP_TICK;
    logic         m_presence  = 1'b1;
    logic [7:0]   m_last_read = '0;

    tick_item_t pending_ticks[$];
    bus_state_t bus_expected[$];
    tick_item_t next_tick;
    bus_state_t got_state;
    bus_state_t want_state;

    int  ticks_queued = 0;
    int  err_count    = 0;
    int  result_cnt   = 0;
    int  send_wait    = 0;
    int  send_run     = 0;
    bit  send_quiet   = 1'b0;
    int  recv_wait    = 0;
    int  recv_run     = 0;
    bit  recv_quiet   = 1'b0;

    one_wire_bus_master u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .data_byte   (data_byte),
        .line_in     (line_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_low   (drive_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_value  (read_value),
        .no_presence (no_presence),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Length of a phase in ticks; a zero register counts as one tick
    function automatic logic [9:0] phase_len(input seq_phase_t ph);
        logic [9:0] v;
        case (ph)
            SQ_RST_LOW:     v = m_reset_low;
            SQ_RST_WAIT:    v = {2'b00, m_presence_wait};
            SQ_RST_RECOVER: v = m_reset_recover;
            SQ_SLOT_START:  v = {6'd0, m_slot_start};
            SQ_W_HOLD:      v = {3'd0, m_slot_hold};
            SQ_W_RECOVER:   v = {6'd0, m_write_recover};
            SQ_R_RELEASE:   v = {6'd0, m_read_sample};
            SQ_R_HOLD:      v = {3'd0, m_slot_hold};
            default:        v = 10'd1;
        endcase
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    // Ticks a command stays busy, finishing tick included
    function automatic int cmd_ticks(input owm_pkg::op_t cmd);
        case (cmd)
            owm_pkg::OP_RESET:
                return int'(phase_len(SQ_RST_LOW)) + int'(phase_len(SQ_RST_WAIT))
                       + int'(phase_len(SQ_RST_RECOVER));
            owm_pkg::OP_WRITE:
                return 8 * (int'(phase_len(SQ_SLOT_START)) + int'(phase_len(SQ_W_HOLD))
                            + int'(phase_len(SQ_W_RECOVER)));
            owm_pkg::OP_READ:
                return 8 * (int'(phase_len(SQ_SLOT_START))
                            + int'(phase_len(SQ_R_RELEASE))
                            + int'(phase_len(SQ_R_HOLD)));
            default:
                return 1;
        endcase
    endfunction

    // Close a bit slot: advance to the next bit or return to idle; 1 when the byte is done
    function automatic logic close_slot();
        if (m_bit == 3'd7) begin
            m_bit   = 3'd0;
            m_phase = SQ_IDLE;
            return 1'b1;
        end
        m_bit   = m_bit + 3'd1;
        m_phase = SQ_SLOT_START;
        return 1'b0;
    endfunction

    // Advance the sequencer by one tick and return the outputs of that tick
    function automatic bus_state_t advance_tick(input owm_pkg::op_t cmd,
                                                input logic [7:0] byte_val,
                                                input logic lvl);
        bus_state_t r;
        r = '0;
        if (m_phase == SQ_IDLE && cmd != owm_pkg::OP_TICK) begin
            m_kind  = cmd;
            m_count = '0;
            m_bit   = '0;
            if (cmd == owm_pkg::OP_RESET) begin
                m_phase = SQ_RST_LOW;
            end else begin
                m_shift = (cmd == owm_pkg::OP_WRITE) ? byte_val : 8'h00;
                m_phase = SQ_SLOT_START;
            end
        end
        if (m_phase != SQ_IDLE) begin
            r.busy      = 1'b1;
            r.drive_low = (m_phase == SQ_RST_LOW) || (m_phase == SQ_SLOT_START)
                          || (m_phase == SQ_W_HOLD && !m_shift[0]);
            m_count = m_count + 10'd1;
            if (m_count >= phase_len(m_phase)) begin
                m_count = '0;
                case (m_phase)
                    SQ_RST_LOW:     m_phase = SQ_RST_WAIT;
                    SQ_RST_WAIT:
                    begin
                        m_presence = lvl;
                        m_phase    = SQ_RST_RECOVER;
                    end
                    SQ_RST_RECOVER:
                    begin
                        m_phase = SQ_IDLE;
                        r.done  = 1'b1;
                    end
                    SQ_SLOT_START:
                        m_phase = (m_kind == owm_pkg::OP_READ) ? SQ_R_RELEASE : SQ_W_HOLD;
                    SQ_W_HOLD:
                    begin
                        m_shift = m_shift >> 1;
                        m_phase = SQ_W_RECOVER;
                    end
                    SQ_W_RECOVER:   r.done = close_slot();
                    SQ_R_RELEASE:
                    begin
                        m_shift = {lvl, m_shift[7:1]};
                        m_phase = SQ_R_HOLD;
                    end
                    SQ_R_HOLD:
                    begin
                        if (close_slot()) begin
                            m_last_read = m_shift;
                            r.done      = 1'b1;
                        end
                    end
                    default:        m_phase = SQ_IDLE;
                endcase
            end
        end
        r.read_value  = m_last_read;
        r.no_presence = m_presence;
        return r;
    endfunction

    // Draw the wait before the next transfer, in busy and quiet stretches chosen at random
    function automatic int draw_pause(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(16, 96);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    // Queue a command followed by the ticks it should stay busy for
    task automatic queue_cmd(input owm_pkg::op_t cmd, input logic [7:0] byte_val,
                             input int lvl_mode, input int noise_pct);
        int         len;
        tick_item_t t;
        len = cmd_ticks(cmd);
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                t.op = cmd;
            else
                t.op = ($urandom_range(0, 99) < noise_pct)
                       ? owm_pkg::op_t'($urandom_range(1, 3)) : owm_pkg::OP_TICK;
            t.data = (i == 0) ? byte_val : 8'($urandom);
            t.lvl  = (lvl_mode == LVL_RAND) ? 1'($urandom) : lvl_mode[0];
            pending_ticks.push_back(t);
        end
        ticks_queued += len;
    endtask

    // Queue idle ticks, some of them carrying stray commands
    task automatic queue_idle(input int n, input int noise_pct);
        tick_item_t t;
        for (int i = 0; i < n; i++) begin
            t.op   = ($urandom_range(0, 99) < noise_pct)
                     ? owm_pkg::op_t'($urandom_range(0, 3)) : owm_pkg::OP_TICK;
            t.data = 8'($urandom);
            t.lvl  = 1'($urandom);
            pending_ticks.push_back(t);
        end
        ticks_queued += n;
    endtask

    // Write one timing register and mirror it once the transfer completes
    task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= owm_pkg::reg_idx_t'(idx);
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (owm_pkg::reg_idx_t'(idx))
            owm_pkg::REG_RESET_LOW:     m_reset_low     = val[9:0];
            owm_pkg::REG_PRESENCE_WAIT: m_presence_wait = val[7:0];
            owm_pkg::REG_RESET_RECOVER: m_reset_recover = val[9:0];
            owm_pkg::REG_SLOT_START:    m_slot_start    = val[3:0];
            owm_pkg::REG_READ_SAMPLE:   m_read_sample   = val[3:0];
            owm_pkg::REG_SLOT_HOLD:     m_slot_hold     = val[6:0];
            owm_pkg::REG_WRITE_RECOVER: m_write_recover = val[3:0];
            default: ;
        endcase
    endtask

    // Hold off until every queued tick is sent and every result is back
    task automatic drain();
        while (pending_ticks.size() != 0 || in_valid || bus_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: feed ticks from the queue, predict each one as its transfer completes
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                bus_expected.push_back(advance_tick(op, data_byte, line_in));
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    next_tick = pending_ticks.pop_front();
                    op        <= next_tick.op;
                    data_byte <= next_tick.data;
                    line_in   <= next_tick.lvl;
                    in_valid  <= 1'b1;
                    send_wait = draw_pause(send_run, send_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, then stall the output side at random
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (bus_expected.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected", result_cnt));
                end else begin
                    want_state = bus_expected.pop_front();
                    got_state  = '{drive_low, busy_res, done_res, read_value, no_presence};
                    if (got_state.drive_low !== want_state.drive_low)
                        report_error($sformatf("result %0d drive_low %b, expected %b",
                                               result_cnt, got_state.drive_low,
                                               want_state.drive_low));
                    if (got_state.busy !== want_state.busy)
                        report_error($sformatf("result %0d busy_res %b, expected %b",
                                               result_cnt, got_state.busy, want_state.busy));
                    if (got_state.done !== want_state.done)
                        report_error($sformatf("result %0d done_res %b, expected %b",
                                               result_cnt, got_state.done, want_state.done));
                    if (got_state.read_value !== want_state.read_value)
                        report_error($sformatf("result %0d read_value %h, expected %h",
                                               result_cnt, got_state.read_value,
                                               want_state.read_value));
                    if (got_state.no_presence !== want_state.no_presence)
                        report_error($sformatf("result %0d no_presence %b, expected %b",
                                               result_cnt, got_state.no_presence,
                                               want_state.no_presence));
                end
                result_cnt++;
                recv_wait = draw_pause(recv_run, recv_quiet);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus: a write under default timing, directed commands under the shortest
    // timing, then random timing sets with zero and up to fifteen ticks per phase
    initial
    begin
        int mark;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Default timing straight out of reset
        queue_cmd(owm_pkg::OP_WRITE, 8'hA5, LVL_RAND, 0);
        queue_idle(3, 0);
        drain();

        // Shortest timing: one tick per phase
        for (int r = 0; r < 7; r++)
            write_reg(r, CFG_W'(1));
        queue_cmd(owm_pkg::OP_RESET, 8'hFF, LVL_HIGH, 0);
        queue_idle(2, 0);
        queue_cmd(owm_pkg::OP_WRITE, 8'h00, LVL_RAND, 0);
        queue_cmd(owm_pkg::OP_WRITE, 8'hFF, LVL_RAND, 0);
        queue_cmd(owm_pkg::OP_WRITE, 8'h80, LVL_RAND, 0);
        queue_cmd(owm_pkg::OP_WRITE, 8'h01, LVL_RAND, 0);
        queue_cmd(owm_pkg::OP_READ, 8'hFF, LVL_LOW, 0);
        queue_cmd(owm_pkg::OP_READ, 8'h00, LVL_HIGH, 0);
        // commands on every busy tick must be ignored
        queue_cmd(owm_pkg::OP_READ, 8'h5A, LVL_RAND, 100);
        queue_cmd(owm_pkg::OP_RESET, 8'h00, LVL_LOW, 100);
        queue_idle(2, 0);
        drain();

        // Random timing sets, mostly short so that many commands complete
        for (int ph = 0; ph < 4; ph++) begin
            for (int r = 0; r < 7; r++)
                write_reg(r, ($urandom_range(0, 7) == 0)
                             ? CFG_W'($urandom_range(1, 15))
                             : CFG_W'($urandom_range(0, 3)));
            mark = ticks_queued;
            while (ticks_queued - mark < 150) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_idle($urandom_range(1, 4), 50);
                end else begin
                    queue_cmd(owm_pkg::op_t'($urandom_range(1, 3)), 8'($urandom),
                              LVL_RAND, 10);
                    if ($urandom_range(0, 2) == 0)
                        queue_idle($urandom_range(1, 3), 0);
                end
            end
            drain();
        end

        if (err_count == 0)
            $display("one_wire_bus_master test passed");
        else
            $display("one_wire_bus_master test failed");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #2_000_000;
        $display("one_wire_bus_master test failed");
        $finish;
    end

endmodule

// File: files.f
design/owm_pkg.sv
design/owm_cfg.sv
design/one_wire_bus_master.sv
test/tb_top.sv
